// ===== design/sba_pkg.sv =====
// ----------------------------------------------------------------------------
// sba_pkg
// Types and codes shared by the subnet bitmap allocator modules.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int unsigned SlotW = 6;
  localparam int unsigned CntW  = 7;
  localparam int unsigned AddrW = 32;
  localparam int unsigned StatW = 3;
  localparam int unsigned PfxW  = 6;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [PfxW-1:0] PfxMax = 6'd32;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [StatW-1:0] ST_OK         = 3'd0;
  localparam logic [StatW-1:0] ST_RANGE      = 3'd1;
  localparam logic [StatW-1:0] ST_TAKEN      = 3'd2;
  localparam logic [StatW-1:0] ST_ZERO_REL   = 3'd3;
  localparam logic [StatW-1:0] ST_NOT_ALLOC  = 3'd4;
  localparam logic [StatW-1:0] ST_MISALIGNED = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_BASE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PREFIX = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_COUNT  = 2'd2;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_EVAL
  } seq_state_e;

  typedef struct packed {
    logic             command;
    logic [SlotW-1:0] slot_index;
  } sba_req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [SlotW-1:0] granted_index;
    logic [AddrW-1:0] subnet_address;
  } sba_rsp_t;

  typedef struct packed {
    logic            done;
    logic [CntW-1:0] slot;
  } sba_scan_t;

endpackage

// ===== design/sba_scan.sv =====
// ----------------------------------------------------------------------------
// sba_scan
// First-fit search: tests one bitmap slot per cycle while step_i is high, lowest slot first.
// ----------------------------------------------------------------------------
module sba_scan
  import sba_pkg::*;
#(
  parameter int unsigned MAX_SUBNETS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic                   step_i,
  input  logic [MAX_SUBNETS-1:0] bitmap_i,
  input  logic [CntW-1:0]        count_i,
  output sba_scan_t              scan_o
);

  localparam int unsigned IdxW = (MAX_SUBNETS > 1) ? $clog2(MAX_SUBNETS) : 1;

  logic [CntW-1:0] slot_q, slot_d;
  logic [CntW-1:0] slot_m1;
  logic [IdxW-1:0] bit_sel;
  logic            hit;

  assign slot_m1 = slot_q - CntW'(1);
  assign bit_sel = slot_m1[IdxW-1:0];
  assign hit     = (slot_q > count_i) || !bitmap_i[bit_sel];

  always_comb begin
    slot_d = slot_q;
    if (load_i) begin
      slot_d = CntW'(1);
    end else if (step_i && !hit) begin
      slot_d = slot_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign scan_o.done = step_i && hit;
  assign scan_o.slot = slot_q;

endmodule

// ===== design/subnet_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// subnet_bitmap_allocator
// Bitmap allocator of subnet slots with first-fit search and address grant.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A command naming a
// slot, or any release, goes from the idle state to the evaluate state and
// back; an allocate of slot 0 first passes through the scan state, where the
// first-fit search walks the bitmap one slot per cycle from slot 1 and stops
// at the first free slot or one past the count. The result appears on rsp_o
// for exactly one cycle with done_o high, the first cycle with busy low; it
// cannot be stalled and must be captured then.
// Configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
module subnet_bitmap_allocator
  import sba_pkg::*;
#(
  parameter int unsigned MAX_SUBNETS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  sba_req_t           req_i,
  output logic               done_o,
  output sba_rsp_t           rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AddrW-1:0]   cfg_data_i
);

  localparam int unsigned IdxW = (MAX_SUBNETS > 1) ? $clog2(MAX_SUBNETS) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SUBNETS);

  logic [AddrW-1:0] base_q;
  logic [PfxW-1:0]  prefix_q;
  logic [SlotW-1:0] count_q;

  seq_state_e state_q, state_d;
  logic             cmd_q, cmd_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [MAX_SUBNETS-1:0] bitmap_q, bitmap_d;
  sba_rsp_t         rsp_q, rsp_d;
  logic             done_q, done_d;

  logic [PfxW-1:0]  eff_pfx;
  logic [PfxW-1:0]  host_bits;
  logic [AddrW:0]   mask_w;
  logic             misaligned;
  logic [CntW-1:0]  eff_cnt;
  logic [CntW-1:0]  idx_m1;
  logic [IdxW-1:0]  bit_sel;
  logic             taken;
  logic [AddrW-1:0] offset;
  logic [AddrW-1:0] grant_addr;
  logic             scan_load;
  logic             scan_step;
  sba_scan_t        scan;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      prefix_q <= 6'd24;
      count_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BASE:   base_q   <= cfg_data_i;
        REG_PREFIX: prefix_q <= cfg_data_i[PfxW-1:0];
        REG_COUNT:  count_q  <= cfg_data_i[SlotW-1:0];
        default:    ;
      endcase
    end
  end

  assign eff_pfx    = (prefix_q > PfxMax) ? PfxMax : prefix_q;
  assign host_bits  = PfxMax - eff_pfx;
  assign mask_w     = ((AddrW+1)'(1) << host_bits) - (AddrW+1)'(1);
  assign misaligned = |(base_q & mask_w[AddrW-1:0]);
  assign eff_cnt    = ({1'b0, count_q} > MaxCnt) ? MaxCnt : {1'b0, count_q};

  assign idx_m1     = idx_q - CntW'(1);
  assign bit_sel    = idx_m1[IdxW-1:0];
  assign taken      = bitmap_q[bit_sel];
  assign offset     = {{(AddrW-SlotW){1'b0}}, idx_m1[SlotW-1:0]} << host_bits;
  assign grant_addr = base_q + offset;

  sba_scan #(
    .MAX_SUBNETS(MAX_SUBNETS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (scan_load),
    .step_i  (scan_step),
    .bitmap_i(bitmap_q),
    .count_i (eff_cnt),
    .scan_o  (scan)
  );

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    bitmap_d  = bitmap_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    scan_load = 1'b0;
    scan_step = 1'b0;
    case (state_q)
      SEQ_IDLE: begin
        if (start) begin
          cmd_d = req_i.command;
          idx_d = {1'b0, req_i.slot_index};
          if (req_i.command == CMD_ALLOC && req_i.slot_index == '0) begin
            scan_load = 1'b1;
            state_d   = SEQ_SCAN;
          end else begin
            state_d = SEQ_EVAL;
          end
        end
      end
      SEQ_SCAN: begin
        scan_step = 1'b1;
        if (scan.done) begin
          idx_d   = scan.slot;
          state_d = SEQ_EVAL;
        end
      end
      SEQ_EVAL: begin
        done_d = 1'b1;
        rsp_d  = '{status: ST_OK, granted_index: '0, subnet_address: '0};
        if (misaligned) begin
          rsp_d.status = ST_MISALIGNED;
        end else if (cmd_q == CMD_ALLOC) begin
          if (idx_q > eff_cnt) begin
            rsp_d.status = ST_RANGE;
          end else if (taken) begin
            rsp_d.status = ST_TAKEN;
          end else begin
            bitmap_d[bit_sel]    = 1'b1;
            rsp_d.granted_index  = idx_q[SlotW-1:0];
            rsp_d.subnet_address = grant_addr;
          end
        end else begin
          if (idx_q == '0) begin
            rsp_d.status = ST_ZERO_REL;
          end else if (idx_q > eff_cnt) begin
            rsp_d.status = ST_RANGE;
          end else if (!taken) begin
            rsp_d.status = ST_NOT_ALLOC;
          end else begin
            bitmap_d[bit_sel]   = 1'b0;
            rsp_d.granted_index = idx_q[SlotW-1:0];
          end
        end
        state_d = SEQ_IDLE;
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SEQ_IDLE;
      bitmap_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      bitmap_q <= bitmap_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != SEQ_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== dv/tb_subnet_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_subnet_bitmap_allocator
// Self-checking bench for the subnet slot allocator.
// ----------------------------------------------------------------------------
// The bench starts with a table of directed commands and register writes. It
// then runs random phases: each one programs a pool, then sends a churn of
// allocates and releases. Each command accepted on the start/busy handshake
// is run through a bench-side copy of the slot bitmap and the pool settings,
// and the expected response is queued. Every done_o strobe is checked field
// by field against the oldest queued response. Table rows whose outcome is
// obvious carry a hand-written response instead.
// ----------------------------------------------------------------------------
module tb_subnet_bitmap_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import sba_pkg::*;

  localparam int unsigned SlotMax       = 32;
  localparam int unsigned LimitCycles   = 500000;
  localparam int unsigned Phases        = 14;
  localparam int unsigned ItemsPerPhase = 78;
  localparam int unsigned MaxShown      = 40;

  typedef struct {
    bit                 is_cfg;
    logic [CfgIdxW-1:0] reg_sel;
    logic [AddrW-1:0]   data;
    sba_req_t           req;
    bit                 pinned;
    sba_rsp_t           rsp;
  } script_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  sba_req_t           req_i       = '0;
  logic               done_o;
  sba_rsp_t           rsp_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = REG_BASE;
  logic [AddrW-1:0]   cfg_data_i  = '0;

  logic               pin_en      = 1'b0;
  sba_rsp_t           pin_rsp     = '0;

  logic [AddrW-1:0]   pool_base   = '0;
  logic [PfxW-1:0]    pool_prefix = 6'd24;
  logic [SlotW-1:0]   pool_count  = '0;
  logic [63:0]        slot_map    = '0;

  sba_rsp_t           grant_queue[$];
  int unsigned        errors      = 0;
  int unsigned        cycles      = 0;
  int unsigned        commands    = 0;
  int unsigned        pool_setups = 0;
  int unsigned        status_seen[8];

  subnet_bitmap_allocator #(
    .MAX_SUBNETS(SlotMax)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic int unsigned live_count();
    return (pool_count > SlotMax) ? SlotMax : pool_count;
  endfunction

  function automatic sba_rsp_t allocate_or_release(sba_req_t r);
    sba_rsp_t         res;
    int unsigned      hbits;
    int unsigned      cnt;
    int unsigned      k;
    logic [63:0]      mask;
    logic [63:0]      sum;
    logic [SlotW-1:0] idx;
    res   = '0;
    hbits = 32 - ((pool_prefix > PfxMax) ? 32 : pool_prefix);
    mask  = (64'd1 << hbits) - 64'd1;
    cnt   = live_count();
    idx   = r.slot_index;
    if (({32'd0, pool_base} & mask) != 64'd0) begin
      res.status = ST_MISALIGNED;
    end else if (r.command == CMD_ALLOC) begin
      if (idx == 0) begin
        k = 1;
        while (k <= cnt && slot_map[k-1]) k++;
        idx = k[SlotW-1:0];
      end
      if (idx > cnt) begin
        res.status = ST_RANGE;
      end else if (slot_map[idx-1]) begin
        res.status = ST_TAKEN;
      end else begin
        slot_map[idx-1]    = 1'b1;
        sum                = {32'd0, pool_base} + (({58'd0, idx} - 64'd1) << hbits);
        res.status         = ST_OK;
        res.granted_index  = idx;
        res.subnet_address = sum[31:0];
      end
    end else if (idx == 0) begin
      res.status = ST_ZERO_REL;
    end else if (idx > cnt) begin
      res.status = ST_RANGE;
    end else if (!slot_map[idx-1]) begin
      res.status = ST_NOT_ALLOC;
    end else begin
      slot_map[idx-1]   = 1'b0;
      res.status        = ST_OK;
      res.granted_index = idx;
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    sba_rsp_t want;
    sba_rsp_t model;
    if (rst_ni) begin
      if (done_o) begin
        status_seen[rsp_o.status]++;
        if (grant_queue.size() == 0) begin
          errors++;
          if (errors <= MaxShown)
            $display("%0t: unexpected result status %0d index %0d addr %08h", $time,
                     rsp_o.status, rsp_o.granted_index, rsp_o.subnet_address);
        end else begin
          want = grant_queue.pop_front();
          if (rsp_o.status !== want.status) begin
            errors++;
            if (errors <= MaxShown)
              $display("%0t: status expected %0d actual %0d", $time, want.status,
                       rsp_o.status);
          end
          if (rsp_o.granted_index !== want.granted_index) begin
            errors++;
            if (errors <= MaxShown)
              $display("%0t: granted_index expected %0d actual %0d", $time,
                       want.granted_index, rsp_o.granted_index);
          end
          if (rsp_o.subnet_address !== want.subnet_address) begin
            errors++;
            if (errors <= MaxShown)
              $display("%0t: subnet_address expected %08h actual %08h", $time,
                       want.subnet_address, rsp_o.subnet_address);
          end
        end
      end
      if (start && !busy) begin
        model = allocate_or_release(req_i);
        grant_queue.push_back(pin_en ? pin_rsp : model);
        commands++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_BASE:   pool_base   = cfg_data_i;
          REG_PREFIX: pool_prefix = cfg_data_i[PfxW-1:0];
          REG_COUNT:  pool_count  = cfg_data_i[SlotW-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("%0t: timeout after %0d cycles, %0d results pending", $time, cycles,
               grant_queue.size());
      $display("tb_subnet_bitmap_allocator: done, errors");
      $finish;
    end
  end

  function automatic int unsigned pick_gap(bit burst);
    if (burst) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 2);
  endfunction

  function automatic script_row_t cfg_row(logic [CfgIdxW-1:0] sel, logic [AddrW-1:0] data);
    script_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.data    = data;
    return row;
  endfunction

  function automatic script_row_t cmd_row(logic cmd, logic [SlotW-1:0] idx);
    script_row_t row;
    row                = '{default: '0};
    row.req.command    = cmd;
    row.req.slot_index = idx;
    return row;
  endfunction

  function automatic script_row_t pin_row(logic cmd, logic [SlotW-1:0] idx,
                                          logic [StatW-1:0] st, logic [SlotW-1:0] gi,
                                          logic [AddrW-1:0] addr);
    script_row_t row;
    row                    = cmd_row(cmd, idx);
    row.pinned             = 1'b1;
    row.rsp.status         = st;
    row.rsp.granted_index  = gi;
    row.rsp.subnet_address = addr;
    return row;
  endfunction

  // Call right after a falling edge; return right after one.
  task automatic send_item(sba_req_t r, bit pinned, sba_rsp_t rsp, int unsigned gap);
    repeat (gap) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start   <= 1'b1;
    req_i   <= r;
    pin_en  <= pinned;
    pin_rsp <= rsp;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (grant_queue.size() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] sel, logic [AddrW-1:0] data, bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    if (last) begin
      cfg_valid_i <= 1'b0;
    end
  endtask

  task automatic program_pool();
    int unsigned pfx;
    int unsigned cnt;
    int unsigned hbits;
    logic [63:0] mask;
    logic [31:0] base;
    logic [31:0] junk;
    case ($urandom_range(0, 9))
      0: pfx = 0;
      1: pfx = 32;
      2: pfx = $urandom_range(33, 63);
      default: pfx = $urandom_range(16, 30);
    endcase
    case ($urandom_range(0, 7))
      0: cnt = 0;
      1: cnt = $urandom_range(33, 63);
      2: cnt = 32;
      3: cnt = 1;
      default: cnt = $urandom_range(2, 31);
    endcase
    hbits = 32 - ((pfx > 32) ? 32 : pfx);
    mask  = (64'd1 << hbits) - 64'd1;
    base  = $urandom;
    // keep most pools aligned so commands reach the bitmap
    if ($urandom_range(0, 7) != 0) base = base & ~mask[31:0];
    junk = $urandom;
    write_reg(REG_BASE, base, 1'b0);
    write_reg(REG_PREFIX, {junk[31:PfxW], pfx[PfxW-1:0]}, 1'b0);
    junk = $urandom;
    write_reg(REG_COUNT, {junk[31:SlotW], cnt[SlotW-1:0]}, 1'b1);
    pool_setups++;
  endtask

  function automatic sba_req_t churn_item();
    sba_req_t    r;
    int unsigned cnt;
    int unsigned pick;
    int unsigned k;
    cnt  = live_count();
    pick = $urandom_range(0, 99);
    r    = '0;
    if (pick < 35) begin
      r.command = CMD_ALLOC;
    end else if (pick < 55) begin
      r.command    = CMD_ALLOC;
      r.slot_index = SlotW'(cnt ? $urandom_range(1, cnt) : $urandom_range(0, 63));
    end else if (pick < 85) begin
      r.command    = CMD_RELEASE;
      r.slot_index = SlotW'(cnt ? $urandom_range(1, cnt) : $urandom_range(0, 63));
      // steer most releases to a slot that is in use
      if (cnt != 0 && $urandom_range(0, 3) != 0) begin
        for (k = 0; k < cnt; k++) begin
          if (slot_map[(r.slot_index - 1 + k) % cnt]) begin
            r.slot_index = SlotW'(((r.slot_index - 1 + k) % cnt) + 1);
            break;
          end
        end
      end
    end else begin
      r.command    = 1'($urandom_range(0, 1));
      r.slot_index = SlotW'($urandom_range(0, 63));
    end
    return r;
  endfunction

  initial begin
    script_row_t script[$];
    bit          burst;
    script = '{
      pin_row(CMD_ALLOC,    6'd0,  ST_RANGE,      6'd0,  32'h0),
      pin_row(CMD_ALLOC,    6'd1,  ST_RANGE,      6'd0,  32'h0),
      pin_row(CMD_RELEASE,  6'd0,  ST_ZERO_REL,   6'd0,  32'h0),
      pin_row(CMD_RELEASE,  6'd63, ST_RANGE,      6'd0,  32'h0),
      cfg_row(REG_BASE,   32'h0A00_0000),
      cfg_row(REG_PREFIX, 32'd24),
      cfg_row(REG_COUNT,  32'd32),
      pin_row(CMD_ALLOC,    6'd0,  ST_OK,         6'd1,  32'h0A00_0000),
      pin_row(CMD_ALLOC,    6'd32, ST_OK,         6'd32, 32'h0A00_1F00),
      pin_row(CMD_ALLOC,    6'd32, ST_TAKEN,      6'd0,  32'h0),
      pin_row(CMD_ALLOC,    6'd33, ST_RANGE,      6'd0,  32'h0),
      pin_row(CMD_ALLOC,    6'd63, ST_RANGE,      6'd0,  32'h0),
      pin_row(CMD_RELEASE,  6'd5,  ST_NOT_ALLOC,  6'd0,  32'h0),
      pin_row(CMD_RELEASE,  6'd32, ST_OK,         6'd32, 32'h0),
      pin_row(CMD_RELEASE,  6'd0,  ST_ZERO_REL,   6'd0,  32'h0),
      cmd_row(CMD_ALLOC,    6'd0),
      cfg_row(REG_BASE,   32'h0A00_0001),
      pin_row(CMD_ALLOC,    6'd0,  ST_MISALIGNED, 6'd0,  32'h0),
      pin_row(CMD_RELEASE,  6'd1,  ST_MISALIGNED, 6'd0,  32'h0),
      cfg_row(REG_BASE,   32'hFFFF_FFFF),
      cfg_row(REG_PREFIX, 32'hFFFF_FFFF),
      cfg_row(REG_COUNT,  32'h0000_003F),
      cmd_row(CMD_ALLOC,    6'd32),
      cmd_row(CMD_ALLOC,    6'd0),
      cmd_row(CMD_RELEASE,  6'd1),
      cfg_row(REG_BASE,   32'h0),
      cfg_row(REG_PREFIX, 32'h0),
      cfg_row(REG_COUNT,  32'd2),
      cmd_row(CMD_ALLOC,    6'd0),
      cmd_row(CMD_ALLOC,    6'd2),
      pin_row(CMD_RELEASE,  6'd3,  ST_RANGE,      6'd0,  32'h0),
      pin_row(CMD_RELEASE,  6'd32, ST_RANGE,      6'd0,  32'h0),
      cfg_row(REG_BASE,   32'h8000_0000),
      cfg_row(REG_PREFIX, 32'd1),
      cfg_row(REG_COUNT,  32'd32),
      cmd_row(CMD_ALLOC,    6'd4),
      cmd_row(CMD_RELEASE,  6'd32)
    };

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < script.size(); i++) begin
      if (script[i].is_cfg) begin
        if (i == 0 || !script[i-1].is_cfg) begin
          drain();
          pool_setups++;
        end
        write_reg(script[i].reg_sel, script[i].data,
                  (i + 1 == script.size()) || !script[i+1].is_cfg);
      end else begin
        send_item(script[i].req, script[i].pinned, script[i].rsp, pick_gap(1'b0));
      end
    end

    for (int p = 0; p < Phases; p++) begin
      drain();
      program_pool();
      burst = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // hold off now and then until the allocator is empty
        if ($urandom_range(0, 39) == 0) drain();
        send_item(churn_item(), 1'b0, '0, pick_gap(burst));
      end
    end

    drain();
    repeat (SlotMax + 8) @(negedge clk_i);
    if (grant_queue.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, grant_queue.size());
    end

    $display("Ran %0d commands across %0d pool setups, mixing first-fit and named slots.",
             commands, pool_setups);
    $display("Outcomes: ok %0d, range %0d, taken %0d, zero-release %0d, free %0d, misaligned %0d",
             status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_TAKEN],
             status_seen[ST_ZERO_REL], status_seen[ST_NOT_ALLOC],
             status_seen[ST_MISALIGNED]);
    if (errors == 0) begin
      $display("tb_subnet_bitmap_allocator: done, clean");
    end else begin
      $display("tb_subnet_bitmap_allocator: done, errors");
    end
    $finish;
  end

endmodule
